// ===== rtl/msvn_pkg.sv =====
// Shared constants for the multi-scale value noise pipeline.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package msvn_pkg;

  localparam int unsigned SCALES = 6;
  localparam int unsigned FREQ_SHIFT = 24;
  localparam int unsigned LANE_LATENCY = 10;
  localparam int unsigned PIPE_LATENCY = LANE_LATENCY + 1;

  localparam int unsigned AMPLITUDE = 120;

  localparam logic [31:0] HASH_MUL = 32'd15731;
  localparam logic [31:0] HASH_ADD = 32'd789221;
  localparam logic [31:0] HASH_OFS = 32'd1376312589;
  localparam logic [31:0] HASH_MASK = 32'h7fff_ffff;
  localparam logic signed [31:0] VALUE_ONE = 32'sh4000_0000;

  localparam logic [23:0] SCALE_FREQ [SCALES] = '{
    24'd167772, 24'd671089, 24'd1342177, 24'd2684355, 24'd5368709, 24'd10754626
  };

  localparam logic [16:0] SCALE_WEIGHT [SCALES] = '{
    17'd65536, 17'd16384, 17'd8192, 17'd4096, 17'd2048, 17'd1022
  };

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_NOISE_SEED = 1'b0;
  localparam cfg_idx_t CFG_ROW_SPAN = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/msvn_hash.sv =====
// Three-stage pipelined integer hash giving one signed Q1.30 corner value.
// Depends on msvn_pkg for the hash constants.
`default_nettype none

module msvn_hash
  import msvn_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic        [31:0] n_i,
  output logic signed [31:0]      value_o
);

  logic [31:0] mix_d, mix_q, sq_q, mix2_q, q_q, h_d;
  logic signed [31:0] value_q;

  assign mix_d = n_i ^ (n_i << 13);
  assign h_d   = (mix2_q * q_q + HASH_OFS) & HASH_MASK;

  always_ff @(posedge clk_i) begin
    mix_q   <= mix_d;
    sq_q    <= mix_d * mix_d;
    mix2_q  <= mix_q;
    q_q     <= sq_q * HASH_MUL + HASH_ADD;
    value_q <= VALUE_ONE - $signed(h_d);
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// ===== rtl/msvn_lane.sv =====
// One lattice scale: position, cell index, four corner hashes, smoothstep
// blending and the weighted term. Depends on msvn_pkg and msvn_hash.
`default_nettype none

module msvn_lane
  import msvn_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned SCALE      = 0
) (
  input  wire logic                  clk_i,
  input  wire logic [COORD_BITS-1:0] x_i,
  input  wire logic [COORD_BITS-1:0] y_i,
  input  wire logic [31:0]           seed_i,
  input  wire logic [15:0]           span_i,
  output logic      [7:0]            term_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned FB = FRAC_BITS;
  localparam int unsigned PW = CB + FREQ_SHIFT;
  localparam logic [23:0] FREQ = SCALE_FREQ[SCALE];
  localparam logic signed [55:0] TERM_K = 56'(AMPLITUDE * SCALE_WEIGHT[SCALE]);
  localparam logic [55:0] BIAS = (56'd1 << 46) - 56'd1;
  localparam logic [FB+1:0] THREE = (FB+2)'(3) << FB;

  function automatic logic signed [31:0] blend(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic [FB:0] s);
    logic signed [32:0]    diff;
    logic signed [FB+34:0] pr;
    logic signed [FB+34:0] sh;
    diff = 33'(b) - 33'(a);
    pr   = (FB+35)'(diff) * (FB+35)'($signed({1'b0, s}));
    sh   = pr >>> FB;
    return a + 32'(sh);
  endfunction

  logic [PW-1:0]    px_q, py_q;
  logic [39:0]      rp_d;
  logic [15:0]      row_q, row2_q;
  logic [CB-1:0]    sx_q;
  logic [CB+15:0]   prod_q;
  logic [FB-1:0]    fx_q, fy_q;
  logic [31:0]      base_d;
  logic [3:0][31:0] corner_q;
  logic [2*FB-1:0]  fxx_d, fyy_d;
  logic [FB-1:0]    tx_q, ty_q;
  logic [FB+1:0]    gx_q, gy_q;
  logic [2*FB+1:0]  sxp_d, syp_d;
  logic [FB:0]      wx4_q, wx5_q, wx6_q, wy4_q, wy5_q, wy6_q, wy7_q;
  logic signed [31:0] val [4];
  logic signed [31:0] a_q, b_q, v_q;
  logic signed [55:0] p_q;
  logic [55:0]      biased_d;
  logic [7:0]       term_q;

  assign rp_d   = 40'(span_i) * 40'(FREQ);
  assign base_d = 32'(sx_q) + 32'(prod_q) + seed_i;
  assign fxx_d  = (2*FB)'(fx_q) * (2*FB)'(fx_q);
  assign fyy_d  = (2*FB)'(fy_q) * (2*FB)'(fy_q);
  assign sxp_d  = (2*FB+2)'(tx_q) * (2*FB+2)'(gx_q);
  assign syp_d  = (2*FB+2)'(ty_q) * (2*FB+2)'(gy_q);
  assign biased_d = p_q[55] ? (56'(p_q) + BIAS) : 56'(p_q);

  always_ff @(posedge clk_i) begin
    px_q   <= PW'(x_i) * PW'(FREQ);
    py_q   <= PW'(y_i) * PW'(FREQ);
    row_q  <= rp_d[39:24];
    sx_q   <= px_q[PW-1:FREQ_SHIFT];
    prod_q <= (CB+16)'(py_q[PW-1:FREQ_SHIFT]) * (CB+16)'(row_q);
    fx_q   <= px_q[FREQ_SHIFT-1 -: FB];
    fy_q   <= py_q[FREQ_SHIFT-1 -: FB];
    row2_q <= row_q;
    corner_q[0] <= base_d;
    corner_q[1] <= base_d + 32'd1;
    corner_q[2] <= base_d + 32'(row2_q);
    corner_q[3] <= base_d + 32'(row2_q) + 32'd1;
    tx_q   <= fxx_d[2*FB-1:FB];
    ty_q   <= fyy_d[2*FB-1:FB];
    gx_q   <= THREE - {1'b0, fx_q, 1'b0};
    gy_q   <= THREE - {1'b0, fy_q, 1'b0};
    wx4_q  <= sxp_d[2*FB:FB];
    wy4_q  <= syp_d[2*FB:FB];
    wx5_q  <= wx4_q;
    wx6_q  <= wx5_q;
    wy5_q  <= wy4_q;
    wy6_q  <= wy5_q;
    wy7_q  <= wy6_q;
    a_q    <= blend(val[0], val[1], wx6_q);
    b_q    <= blend(val[2], val[3], wx6_q);
    v_q    <= blend(a_q, b_q, wy7_q);
    p_q    <= 56'(v_q) * TERM_K;
    term_q <= biased_d[53:46];
  end

  for (genvar c = 0; c < 4; c++) begin : g_corner
    msvn_hash u_hash (
      .clk_i   (clk_i),
      .n_i     (corner_q[c]),
      .value_o (val[c])
    );
  end

  assign term_o = term_q;

endmodule

`default_nettype wire

// ===== rtl/multi_scale_value_noise_pixel_top.sv =====
// Top level of the multi-scale value noise block: configuration registers,
// six scale lanes, the valid line and the output sum. Depends on msvn_pkg, msvn_lane.
`default_nettype none

// One pixel transaction is accepted in every cycle in which start_i is high;
// busy_o stays low. Each result appears on pixel_value_o with valid_o high for
// one cycle, after the lane pipeline (position, cell index, corner indices,
// three hash stages, two blends, weighting, term) and the output sum register.
// Results leave in input order and the receiver cannot stall them. The user
// must write registers only while idle; the block does not enforce it.
module multi_scale_value_noise_pixel_top
  import msvn_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [9:0]  x_coord_i,
  input  wire logic [9:0]  y_coord_i,
  output logic             valid_o,
  output logic [7:0]       pixel_value_o,
  input  wire logic        cfg_we_i,
  input  wire cfg_idx_t    cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  logic [31:0] seed_q;
  logic [15:0] span_q;
  logic [PIPE_LATENCY-1:0] vld_q;
  logic [COORD_BITS-1:0] x_c, y_c;
  logic [7:0] term [SCALES];
  logic [7:0] sum_d, pix_q;

  assign x_c = COORD_BITS'(x_coord_i);
  assign y_c = COORD_BITS'(y_coord_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      span_q <= 16'd181;
      vld_q  <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_LATENCY-2:0], start_i};
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NOISE_SEED: seed_q <= cfg_data_i;
          CFG_ROW_SPAN:   span_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  for (genvar k = 0; k < SCALES; k++) begin : g_lane
    msvn_lane #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .SCALE      (k)
    ) u_lane (
      .clk_i  (clk_i),
      .x_i    (x_c),
      .y_i    (y_c),
      .seed_i (seed_q),
      .span_i (span_q),
      .term_o (term[k])
    );
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < SCALES; k++) begin
      sum_d = sum_d + term[k];
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= sum_d;
  end

  assign busy_o        = 1'b0;
  assign valid_o       = vld_q[PIPE_LATENCY-1];
  assign pixel_value_o = pix_q;

endmodule

`default_nettype wire

// ===== rtl/msvn_chk.sv =====
// Port-level checker for the value noise block, bound to the top level.
// Depends on msvn_pkg for the pipeline latency.
`default_nettype none

module msvn_chk
  import msvn_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic valid_o
);

  // Every transaction yields exactly one result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##PIPE_LATENCY valid_o)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, PIPE_LATENCY))
    else $error("result without a matching transaction");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("block refused a transaction");

endmodule

bind multi_scale_value_noise_pixel_top msvn_chk u_msvn_chk (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .valid_o (valid_o)
);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for multi_scale_value_noise_pixel_top: directed and random pixels
// are checked against a built-in noise predictor. Depends on msvn_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import msvn_pkg::*;

  localparam int unsigned LIMIT = 200000;
  localparam int unsigned DRAIN = PIPE_LATENCY + 4;

  typedef struct {
    bit          is_write;
    cfg_idx_t    reg_idx;
    logic [31:0] reg_data;
    logic [9:0]  x;
    logic [9:0]  y;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [9:0]  x_coord_i = '0;
  logic [9:0]  y_coord_i = '0;
  logic        cfg_we_i = 1'b0;
  cfg_idx_t    cfg_idx_i = CFG_NOISE_SEED;
  logic [31:0] cfg_data_i = '0;
  logic        busy_o;
  logic        valid_o;
  logic [7:0]  pixel_value_o;

  logic [31:0] seed_q = '0;
  logic [15:0] span_q = 16'd181;
  logic [7:0]  pixel_queue[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;

  multi_scale_value_noise_pixel_top DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .x_coord_i, .y_coord_i,
    .valid_o, .pixel_value_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  function automatic longint corner(logic [31:0] n);
    logic [31:0] h;
    n = (n << 13) ^ n;
    h = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
    return longint'(64'd1 << 30) - longint'({32'd0, h});
  endfunction

  function automatic longint smooth(longint f);
    longint t;
    t = (f * f) >> 16;
    return (t * ((64'd3 << 16) - 2 * f)) >> 16;
  endfunction

  function automatic longint mix(longint a, longint b, longint s);
    return a + (((b - a) * s) >>> 16);
  endfunction

  function automatic logic [7:0] noise_pixel(logic [9:0] x, logic [9:0] y,
                                             logic [31:0] seed, logic [15:0] span);
    longint fq, px, py, wx, wy, a, b, v, p;
    logic [31:0] sx, sy, row, base;
    logic [63:0] sum;
    sum = '0;
    for (int k = 0; k < SCALES; k++) begin
      fq = longint'(SCALE_FREQ[k]);
      px = longint'(x) * fq;
      py = longint'(y) * fq;
      sx = 32'(px >> 24);
      sy = 32'(py >> 24);
      row = 32'((longint'(span) * fq) >> 24);
      base = sx + sy * row + seed;
      wx = smooth((px >> 8) & 64'hffff);
      wy = smooth((py >> 8) & 64'hffff);
      a = mix(corner(base), corner(base + 32'd1), wx);
      b = mix(corner(base + row), corner(base + row + 32'd1), wx);
      v = mix(a, b, wy);
      p = v * 120 * longint'(SCALE_WEIGHT[k]);
      sum += (p < 0) ? -((-p) >> 46) : (p >> 46);
    end
    return sum[7:0];
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (valid_o) begin
      if (pixel_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel transaction: %0d", pixel_value_o);
      end else begin
        if (pixel_value_o !== pixel_queue[0]) begin
          errors++;
          if (errors <= 10)
            $display("pixel mismatch: expected %0d, got %0d", pixel_queue[0], pixel_value_o);
        end
        void'(pixel_queue.pop_front());
      end
    end
    if (rst_ni && start_i && !busy_o)
      pixel_queue.push_back(noise_pixel(x_coord_i, y_coord_i, seed_q, span_q));
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_NOISE_SEED) seed_q <= cfg_data_i;
      else if (cfg_idx_i == CFG_ROW_SPAN) span_q <= cfg_data_i[15:0];
    end
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_pixel(logic [9:0] x, logic [9:0] y, int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    x_coord_i <= x;
    y_coord_i <= y;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    start_i <= 1'b0;
    @(negedge clk_i);
    wait (pixel_queue.size() == 0);
    repeat (DRAIN) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  stim_row_t directed[] = '{
    '{0, CFG_NOISE_SEED, 0, 10'd0, 10'd0},
    '{0, CFG_NOISE_SEED, 0, 10'd1023, 10'd1023},
    '{0, CFG_NOISE_SEED, 0, 10'd1023, 10'd0},
    '{0, CFG_NOISE_SEED, 0, 10'd0, 10'd1023},
    '{0, CFG_NOISE_SEED, 0, 10'h2aa, 10'h155},
    '{0, CFG_NOISE_SEED, 0, 10'h155, 10'h2aa},
    '{0, CFG_NOISE_SEED, 0, 10'd99, 10'd101},
    '{1, CFG_NOISE_SEED, 32'hffff_ffff, 10'd0, 10'd0},
    '{0, CFG_NOISE_SEED, 0, 10'd0, 10'd0},
    '{0, CFG_NOISE_SEED, 0, 10'd1023, 10'd1023},
    '{1, CFG_ROW_SPAN, 32'd0, 10'd0, 10'd0},
    '{0, CFG_NOISE_SEED, 0, 10'd512, 10'd700},
    '{0, CFG_NOISE_SEED, 0, 10'd1023, 10'd1023},
    '{1, CFG_ROW_SPAN, 32'h0000_ffff, 10'd0, 10'd0},
    '{0, CFG_NOISE_SEED, 0, 10'd1023, 10'd1023},
    '{0, CFG_NOISE_SEED, 0, 10'd3, 10'd1000},
    '{1, CFG_ROW_SPAN, 32'd1, 10'd0, 10'd0},
    '{0, CFG_NOISE_SEED, 0, 10'd1023, 10'd1023},
    '{0, CFG_NOISE_SEED, 0, 10'd17, 10'd29}
  };

  int unsigned idle_pct[4] = '{0, 88, 21, 0};

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) begin
      if (directed[i].is_write) write_reg(directed[i].reg_idx, directed[i].reg_data);
      else send_pixel(directed[i].x, directed[i].y, 0);
    end
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: write_reg(CFG_NOISE_SEED, $urandom());
        1: write_reg(CFG_ROW_SPAN, $urandom_range(0, 65535));
        2: write_reg(CFG_ROW_SPAN, (ph < 4) ? 32'd181 : 32'd65535);
        default: write_reg(CFG_NOISE_SEED, (ph < 4) ? 32'd0 : 32'hffff_fff0);
      endcase
      for (int n = 0; n < 175; n++) begin
        if ($urandom_range(0, 9) == 0)
          send_pixel($urandom_range(0, 1) ? 10'd1023 : 10'd0, 10'($urandom_range(0, 1023)),
                     idle_pct[ph % 4]);
        else
          send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                     idle_pct[ph % 4]);
      end
    end
    start_i <= 1'b0;
    wait (pixel_queue.size() == 0);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0 && pixel_queue.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
